FILE: hw/rtl/cwt_pkg.sv
// Package for the cubic window target block: item kinds, sequencer states,
// default tick rate. No dependencies.
`timescale 1ns / 1ps
package cwt_pkg;
  localparam int unsigned TickRateDefault = 1000;
  localparam logic [1:0] KIND_COMPUTE = 2'd0;
  localparam logic [1:0] KIND_LOSS    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_CBRT, ST_CUBE, ST_DIV, ST_FINISH, ST_OUT
  } state_t;
endpackage

FILE: hw/rtl/cubic_window_target.sv
// Cubic window target. Loss and restart transactions give no result; kind 3
// is ignored. A compute transaction runs the serial divide that scales the
// peak for K, 22 cube-root steps of 3 bits each, two shift-add passes for the
// cube (one bit a cycle), the serial divide that gives d, and then floors and
// registers the target. The two serial divides are the longest steps. One
// item is in work at a time and the input is held off while a result waits,
// so a new compute transaction is accepted only after the previous result
// has been taken.
`timescale 1ns / 1ps
module cubic_window_target #(
  parameter int unsigned TICK_RATE = cwt_pkg::TickRateDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // now_ticks[31:0], cwnd[63:32]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // target[31:0]
  output logic        m_tuser    // grow
);
  localparam logic [31:0] UnitMul = 32'(1000000 / TICK_RATE);
  localparam logic [63:0] DDiv    = 64'(64'd1000000000000 / 64'(TICK_RATE));

  cwt_pkg::state_t state, state_next;
  logic [31:0] epoch, peak, cwnd_r, t, offs;
  logic        t_lt_k;
  logic [63:0] x, acc, mcand;
  logic [31:0] y;
  logic [31:0] mplier;
  logic [5:0]  cnt;
  logic        pass2;
  logic        div_start, div_done;
  logic [63:0] div_a, div_b, div_q;
  logic [31:0] now_i, cwnd_i;
  logic [31:0] tgt;

  assign now_i  = s_tdata[31:0];
  assign cwnd_i = s_tdata[63:32];
  assign s_tready = (state == cwt_pkg::ST_IDLE) && !m_tvalid;

  cwt_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  // peak*1e6/TICK_RATE/10 == peak*100000/TICK_RATE (floors compose)
  assign div_b = (state == cwt_pkg::ST_SCALE) ? 64'(TICK_RATE) : DDiv;
  assign div_a = (state == cwt_pkg::ST_SCALE) ? 64'(peak) * 64'd100000 : acc;

  always_ff @(posedge clk) begin
    if (rst) state <= cwt_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // cnt == 63 marks the first cycle of a divide state, where the divider starts
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      cwt_pkg::ST_IDLE:
        if (s_tvalid && s_tready && s_tuser == cwt_pkg::KIND_COMPUTE) begin
          state_next = cwt_pkg::ST_SCALE;
        end
      cwt_pkg::ST_SCALE: begin
        if (div_done) state_next = cwt_pkg::ST_CBRT;
        else if (cnt == 6'd63) div_start = 1'b1;
      end
      cwt_pkg::ST_CBRT:   if (cnt == 6'd21) state_next = cwt_pkg::ST_CUBE;
      cwt_pkg::ST_CUBE:   if (cnt == 6'd31 && pass2) state_next = cwt_pkg::ST_DIV;
      cwt_pkg::ST_DIV: begin
        if (div_done) state_next = cwt_pkg::ST_FINISH;
        else if (cnt == 6'd63) div_start = 1'b1;
      end
      cwt_pkg::ST_FINISH: state_next = cwt_pkg::ST_OUT;
      cwt_pkg::ST_OUT:    state_next = cwt_pkg::ST_IDLE;
      default:            state_next = cwt_pkg::ST_IDLE;
    endcase
  end

  // cube-root step: 3 bits of x per cycle, from the top
  logic [31:0] y2, y_new, offs_new;
  logic [63:0] bstep, xs;
  logic [6:0]  sh;
  logic        lt_new;
  always_comb begin
    sh       = 7'd63 - 7'(cnt) * 7'd3;
    y2       = {y[30:0], 1'b0};
    bstep    = 64'd3 * (64'(y2) * 64'(y2 + 32'd1)) + 64'd1;
    xs       = x >> sh;
    y_new    = (xs >= bstep) ? y2 + 32'd1 : y2;
    lt_new   = t < y_new;
    offs_new = lt_new ? y_new - t : t - y_new;
  end

  // shift-add multiply mod 2^64, one multiplier bit per cycle
  logic [63:0] prod;
  assign prod = mplier[0] ? acc + mcand : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch    <= '0;
      peak     <= '0;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      pass2    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        cwt_pkg::ST_IDLE:
          if (s_tvalid && s_tready) begin
            cnt <= 6'd63;
            unique case (s_tuser)
              cwt_pkg::KIND_LOSS:    begin peak <= cwnd_i; epoch <= '0; end
              cwt_pkg::KIND_RESTART: epoch <= '0;
              cwt_pkg::KIND_COMPUTE: begin
                cwnd_r <= cwnd_i;
                if (epoch == '0) begin
                  epoch <= now_i;
                  if (cwnd_i > peak) peak <= cwnd_i;
                  t <= '0;
                end else begin
                  t <= (now_i - epoch) * UnitMul;
                end
              end
              default: ;
            endcase
          end
        cwt_pkg::ST_SCALE: begin
          cnt <= '0;
          if (div_done) begin
            x <= div_q;
            y <= '0;
          end
        end
        cwt_pkg::ST_CBRT: begin
          if (xs >= bstep) x <= x - (bstep << sh);
          y <= y_new;
          if (cnt == 6'd21) begin
            cnt    <= '0;
            pass2  <= 1'b0;
            t_lt_k <= lt_new;
            offs   <= offs_new;
            mcand  <= 64'(offs_new);
            mplier <= offs_new;
            acc    <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        cwt_pkg::ST_CUBE: begin
          if (cnt == 6'd31) begin
            if (!pass2) begin
              cnt    <= '0;
              pass2  <= 1'b1;
              mcand  <= prod;
              mplier <= offs;
              acc    <= '0;
            end else begin
              cnt <= 6'd63;
              acc <= (prod << 3) + (prod << 1);
            end
          end else begin
            cnt    <= cnt + 6'd1;
            acc    <= prod;
            mcand  <= {mcand[62:0], 1'b0};
            mplier <= {1'b0, mplier[31:1]};
          end
        end
        cwt_pkg::ST_DIV: cnt <= '0;
        cwt_pkg::ST_FINISH: begin
          if (t_lt_k) tgt <= (peak > div_q[31:0]) ? peak - div_q[31:0] : '0;
          else        tgt <= peak + div_q[31:0];
        end
        cwt_pkg::ST_OUT: begin
          m_tdata  <= (tgt < 32'd2) ? 32'd2 : tgt;
          m_tuser  <= ((tgt < 32'd2) ? 32'd2 : tgt) > cwnd_r;
          m_tvalid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != cwt_pkg::ST_IDLE) |-> !s_tready) else $error("accept while busy");
  a_target_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >= 32'd2)) else $error("target below floor");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result dropped");
`endif
endmodule

FILE: hw/rtl/cwt_divider.sv
// Bit-serial restoring divider, 64-bit dividend by a 64-bit divisor.
// Depends on nothing; one quotient bit per cycle.
`timescale 1ns / 1ps
module cwt_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [64:0] rem;
  logic [63:0] quo;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  always_comb trial = {rem[63:0], quo[63]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= '0;
      quo  <= dividend;
      cnt  <= 7'd64;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[63:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = quo;
endmodule
